/* src/scpfp_pkg.sv */
// Package for the seven-colour pixel format packer.
// Holds format and register codes, panel colour codes and the palette tables.
// No dependencies.
`timescale 1ns / 1ps

package scpfp_pkg;

    typedef enum logic [1:0] {
        FMT_MONO    = 2'd0,
        FMT_THREE   = 2'd1,
        FMT_NATIVE  = 2'd2,
        FMT_PALETTE = 2'd3
    } t_fmt;

    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_INVERT       = 2'd1,
        REG_PALETTE_TBL  = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    localparam int unsigned CFG_DATA_W = 2;
    localparam int unsigned RESULTS_MAX = 4;
    localparam int unsigned RES_IDX_W = $clog2(RESULTS_MAX);

    localparam logic [3:0] CODE_BLACK  = 4'd0;
    localparam logic [3:0] CODE_WHITE  = 4'd1;
    localparam logic [3:0] CODE_GREEN  = 4'd2;
    localparam logic [3:0] CODE_BLUE   = 4'd3;
    localparam logic [3:0] CODE_RED    = 4'd4;
    localparam logic [3:0] CODE_YELLOW = 4'd5;
    localparam logic [3:0] CODE_ORANGE = 4'd6;

    localparam logic [1:0] TBL_ZERO = 2'd0;
    localparam logic [1:0] TBL_ONE  = 2'd1;

    typedef struct packed {
        logic [RESULTS_MAX-1:0][7:0] bytes;
        logic [RES_IDX_W-1:0]        last_idx;
    } t_conv_res;

    function automatic logic [3:0] quantize(input logic [7:0] v, input logic [1:0] tbl);
        logic [3:0] code;
        code = CODE_WHITE;
        case (tbl)
            TBL_ZERO: begin
                case (v)
                    8'hFF:   code = CODE_WHITE;
                    8'hFC:   code = CODE_YELLOW;
                    8'hF1:   code = CODE_ORANGE;
                    8'hE5:   code = CODE_RED;
                    8'h4B:   code = CODE_BLUE;
                    8'h39:   code = CODE_GREEN;
                    8'h00:   code = CODE_BLACK;
                    default: code = CODE_WHITE;
                endcase
            end
            TBL_ONE: begin
                case (v)
                    8'h00:   code = CODE_BLACK;
                    8'hFF:   code = CODE_WHITE;
                    8'hFC:   code = CODE_YELLOW;
                    8'hE0:   code = CODE_RED;
                    8'h03:   code = CODE_BLUE;
                    8'h1C:   code = CODE_GREEN;
                    default: code = CODE_WHITE;
                endcase
            end
            default: code = CODE_WHITE;
        endcase
        return code;
    endfunction

endpackage

/* src/scpfp_in_if.sv */
// Input channel interface: source pixel bytes with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps

interface scpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;

    modport source (output valid, output first_byte, output second_byte, input ready);
    modport sink   (input valid, input first_byte, input second_byte, output ready);
endinterface

/* src/scpfp_out_if.sv */
// Output channel interface: native panel bytes with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps

interface scpfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] native_byte;
    logic       run_last;

    modport source (output valid, output native_byte, output run_last, input ready);
    modport sink   (input valid, input native_byte, input run_last, output ready);
endinterface

/* src/scpfp_conv.sv */
// Conversion logic: expands one registered source transaction into up to four
// native bytes. Depends on scpfp_pkg.
`timescale 1ns / 1ps

module scpfp_conv
    import scpfp_pkg::*;
(
    input  logic [7:0] i_first,
    input  logic [7:0] i_second,
    input  t_fmt       i_fmt,
    input  logic       i_invert,
    input  logic [1:0] i_tbl,
    output t_conv_res  o_res
);

    logic [7:0] a;
    logic [7:0] b;
    logic [3:0] codes [8];

    assign a = i_invert ? ~i_first  : i_first;
    assign b = i_invert ? ~i_second : i_second;

    always_comb begin
        for (int p = 0; p < 8; p++) begin
            if (i_fmt == FMT_THREE && !b[p]) begin
                codes[p] = CODE_RED;
            end else begin
                codes[p] = {3'b000, a[p]};
            end
        end
    end

    always_comb begin
        o_res = '0;
        case (i_fmt)
            FMT_PALETTE: begin
                o_res.bytes[0] = {quantize(i_first, i_tbl), quantize(i_second, i_tbl)};
                o_res.last_idx = '0;
            end
            FMT_NATIVE: begin
                o_res.bytes[0] = a;
                o_res.last_idx = '0;
            end
            FMT_MONO, FMT_THREE: begin
                for (int k = 0; k < RESULTS_MAX; k++) begin
                    o_res.bytes[k] = {codes[7 - 2*k], codes[6 - 2*k]};
                end
                o_res.last_idx = RES_IDX_W'(RESULTS_MAX - 1);
            end
            default: o_res = '0;
        endcase
    end

endmodule

/* src/seven_color_pixel_format_packer_top.sv */
// Top level of the seven-colour pixel format packer: configuration registers,
// input register, byte sequencer and output register. Depends on scpfp_pkg,
// scpfp_in_if, scpfp_out_if and scpfp_conv.
//
//  channel  | direction | payload                   | handshake
//  i_in     | in        | first_byte, second_byte   | valid/ready
//  o_out    | out       | native_byte, run_last     | valid/ready
//  i_cfg_*  | in        | register index, data      | write enable only
//
// One native byte leaves per cycle while the output is not stalled: mono and
// three-colour transactions yield four bytes each, native and palette
// transactions one. The next transaction is taken in the cycle its predecessor's
// last byte moves to the output register. Synchronous active-low reset clears
// the configuration registers, byte index and valid flags. A stalled output
// holds its byte and back-pressures the input register.
`timescale 1ns / 1ps

module seven_color_pixel_format_packer_top
    import scpfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    scpfp_in_if.sink              i_in,
    scpfp_out_if.source           o_out
);

    t_fmt                 r_fmt;
    logic                 r_invert;
    logic [1:0]           r_tbl;

    logic                 r_in_valid;
    logic [7:0]           r_first;
    logic [7:0]           r_second;
    logic [RES_IDX_W-1:0] r_idx;
    logic [RES_IDX_W-1:0] n_idx;

    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    t_conv_res            conv_res;
    logic                 out_load;
    logic                 cur_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_MONO;
            r_invert <= 1'b0;
            r_tbl    <= TBL_ZERO;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PIXEL_FORMAT: r_fmt    <= t_fmt'(i_cfg_wdata[1:0]);
                REG_INVERT:       r_invert <= i_cfg_wdata[0];
                REG_PALETTE_TBL:  r_tbl    <= i_cfg_wdata[1:0];
                default:          ;
            endcase
        end
    end

    scpfp_conv u_conv (
        .i_first  (r_first),
        .i_second (r_second),
        .i_fmt    (r_fmt),
        .i_invert (r_invert),
        .i_tbl    (r_tbl),
        .o_res    (conv_res)
    );

    assign cur_last   = (r_idx == conv_res.last_idx);
    assign out_load   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || (out_load && cur_last);

    always_comb begin
        n_idx = r_idx;
        if (out_load) begin
            n_idx = cur_last ? '0 : r_idx + 1'b1;
        end
    end

    // input register and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (out_load && cur_last) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_first  <= i_in.first_byte;
            r_second <= i_in.second_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= conv_res.bytes[r_idx];
            r_out_last <= cur_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.native_byte = r_out_byte;
    assign o_out.run_last    = r_out_last;

`ifndef ASSERT_OFF
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> r_idx == '0)
        else $error("byte index advanced with no transaction held");

    a_mid_run_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.run_last |-> r_in_valid)
        else $error("non-final byte shown without its transaction held");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_in_valid)
        else $error("accepted transaction lost from input register");

    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && cur_last |=> r_idx == '0 && o_out.valid && o_out.run_last)
        else $error("final byte did not rewind the sequencer");
`endif

endmodule

/* tb/sv/seven_color_pixel_format_packer_top_test.sv */
// Testbench for seven_color_pixel_format_packer_top: directed table plus random traffic.
// Results are checked against table values or an in-bench model of the packing rules.
// Depends on scpfp_pkg, scpfp_in_if, scpfp_out_if and the packer top level.
`timescale 1ns / 1ps

module seven_color_pixel_format_packer_top_test;
    import scpfp_pkg::*;

    typedef struct packed {
        logic [7:0] native_byte;
        logic       run_last;
    } panel_byte_t;

    typedef struct packed {
        t_fmt       fmt;
        logic       inv;
        logic [1:0] tbl;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic       typed;
        logic [7:0] want;
    } pattern_row_t;

    localparam int unsigned PATTERN_N = 25;
    localparam int unsigned RAND_PHASES = 12;
    localparam int unsigned PHASE_ITEMS = 24;

    localparam pattern_row_t PATTERN_ROWS [PATTERN_N] = '{
        '{FMT_MONO,    1'b0, 2'd0, 8'hFF, 8'h00, 1'b1, 8'h11},
        '{FMT_MONO,    1'b0, 2'd0, 8'h00, 8'hFF, 1'b1, 8'h00},
        '{FMT_MONO,    1'b0, 2'd0, 8'hA5, 8'h5A, 1'b0, 8'h00},
        '{FMT_MONO,    1'b1, 2'd0, 8'hFF, 8'h00, 1'b1, 8'h00},
        '{FMT_MONO,    1'b1, 2'd0, 8'h00, 8'h00, 1'b1, 8'h11},
        '{FMT_THREE,   1'b0, 2'd0, 8'hFF, 8'hFF, 1'b1, 8'h11},
        '{FMT_THREE,   1'b0, 2'd0, 8'h00, 8'hFF, 1'b1, 8'h00},
        '{FMT_THREE,   1'b0, 2'd0, 8'hFF, 8'h00, 1'b1, 8'h44},
        '{FMT_THREE,   1'b0, 2'd0, 8'h5A, 8'hC3, 1'b0, 8'h00},
        '{FMT_THREE,   1'b1, 2'd0, 8'h00, 8'h00, 1'b1, 8'h11},
        '{FMT_THREE,   1'b1, 2'd0, 8'hFF, 8'hFF, 1'b1, 8'h44},
        '{FMT_NATIVE,  1'b0, 2'd0, 8'h00, 8'hFF, 1'b1, 8'h00},
        '{FMT_NATIVE,  1'b0, 2'd0, 8'hFF, 8'h00, 1'b1, 8'hFF},
        '{FMT_NATIVE,  1'b1, 2'd0, 8'h00, 8'h00, 1'b1, 8'hFF},
        '{FMT_NATIVE,  1'b1, 2'd0, 8'hA5, 8'h3C, 1'b0, 8'h00},
        '{FMT_PALETTE, 1'b1, 2'd0, 8'hFF, 8'hFC, 1'b1, 8'h15},
        '{FMT_PALETTE, 1'b1, 2'd0, 8'hF1, 8'hE5, 1'b1, 8'h64},
        '{FMT_PALETTE, 1'b1, 2'd0, 8'h4B, 8'h39, 1'b1, 8'h32},
        '{FMT_PALETTE, 1'b1, 2'd0, 8'h00, 8'h12, 1'b1, 8'h01},
        '{FMT_PALETTE, 1'b0, 2'd1, 8'h00, 8'hFF, 1'b1, 8'h01},
        '{FMT_PALETTE, 1'b0, 2'd1, 8'hFC, 8'hE0, 1'b1, 8'h54},
        '{FMT_PALETTE, 1'b0, 2'd1, 8'h03, 8'h1C, 1'b1, 8'h32},
        '{FMT_PALETTE, 1'b0, 2'd1, 8'hE5, 8'hFF, 1'b1, 8'h11},
        '{FMT_PALETTE, 1'b0, 2'd2, 8'h00, 8'hFC, 1'b1, 8'h11},
        '{FMT_PALETTE, 1'b0, 2'd3, 8'h00, 8'hFF, 1'b1, 8'h11}
    };

    localparam logic [7:0] PALETTE_KEYS [10] = '{
        8'hFF, 8'hFC, 8'hF1, 8'hE5, 8'h4B, 8'h39, 8'h00, 8'hE0, 8'h03, 8'h1C
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    scpfp_in_if  pix_in();
    scpfp_out_if pix_out();

    seven_color_pixel_format_packer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (pix_in.sink),
        .o_out       (pix_out.source)
    );

    t_fmt        cfg_fmt;
    logic        cfg_inv;
    logic [1:0]  cfg_tbl;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned mismatch_count;
    panel_byte_t pending_bytes[$];

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("seven_color_pixel_format_packer_top: mismatch");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        mismatch_count++;
        $display("%0t ns: %s: got %02h, want %02h", $time, what, got, want);
    endtask

    function automatic logic [3:0] palette_code(input logic [7:0] v, input logic [1:0] tbl);
        logic [3:0] code;
        code = CODE_WHITE;
        if (tbl == TBL_ZERO) begin
            case (v)
                8'h00: code = CODE_BLACK;
                8'hFC: code = CODE_YELLOW;
                8'hF1: code = CODE_ORANGE;
                8'hE5: code = CODE_RED;
                8'h4B: code = CODE_BLUE;
                8'h39: code = CODE_GREEN;
                default: code = CODE_WHITE;
            endcase
        end else if (tbl == TBL_ONE) begin
            case (v)
                8'h00: code = CODE_BLACK;
                8'hFC: code = CODE_YELLOW;
                8'hE0: code = CODE_RED;
                8'h03: code = CODE_BLUE;
                8'h1C: code = CODE_GREEN;
                default: code = CODE_WHITE;
            endcase
        end
        return code;
    endfunction

    // Queue the panel bytes one source transaction yields under the current settings.
    function automatic void predict_panel_bytes(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] pa;
        logic [7:0] pb;
        logic [7:0] packed_px;
        logic [3:0] code;
        int         bit_n;
        if (cfg_fmt == FMT_PALETTE) begin
            pending_bytes.push_back('{{palette_code(a, cfg_tbl), palette_code(b, cfg_tbl)},
                                      1'b1});
            return;
        end
        pa = cfg_inv ? ~a : a;
        pb = cfg_inv ? ~b : b;
        if (cfg_fmt == FMT_NATIVE) begin
            pending_bytes.push_back('{pa, 1'b1});
            return;
        end
        for (int k = 0; k < 4; k++) begin
            packed_px = 8'h00;
            for (int p = 0; p < 2; p++) begin
                bit_n = 7 - 2 * k - p;
                if (cfg_fmt == FMT_THREE && !pb[bit_n])
                    code = CODE_RED;
                else
                    code = pa[bit_n] ? CODE_WHITE : CODE_BLACK;
                packed_px = {packed_px[3:0], code};
            end
            pending_bytes.push_back('{packed_px, k == 3});
        end
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_PIXEL_FORMAT: cfg_fmt = t_fmt'(data[1:0]);
            REG_INVERT:       cfg_inv = data[0];
            REG_PALETTE_TBL:  cfg_tbl = data[1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input t_fmt fmt, input logic [1:0] inv_data,
                               input logic [1:0] tbl);
        write_reg(REG_PIXEL_FORMAT, fmt);
        write_reg(REG_INVERT, inv_data);
        write_reg(REG_PALETTE_TBL, tbl);
        write_reg(REG_UNUSED, 2'($urandom_range(3)));
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every pending byte, then idle for the requested cycle count.
    task automatic settle(input int unsigned cycles);
        pix_in.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_pixels(input logic [7:0] a, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.first_byte  <= a;
        pix_in.second_byte <= b;
        @(posedge i_clk);
        while (!pix_in.ready)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : out_check
        panel_byte_t want;
        if (pix_out.valid && pix_out.ready) begin
            if (pending_bytes.size() == 0) begin
                flag_mismatch("byte with none pending", pix_out.native_byte, 8'h00);
            end else begin
                want = pending_bytes.pop_front();
                if (pix_out.native_byte !== want.native_byte)
                    flag_mismatch("native_byte", pix_out.native_byte, want.native_byte);
                if (pix_out.run_last !== want.run_last)
                    flag_mismatch("run_last", {7'd0, pix_out.run_last}, {7'd0, want.run_last});
            end
        end
        pix_out.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin : stimulus
        pattern_row_t row;
        logic [7:0]   a;
        logic [7:0]   b;
        int unsigned  n;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= REG_PIXEL_FORMAT;
        i_cfg_wdata        <= '0;
        pix_in.valid       <= 1'b0;
        pix_in.first_byte  <= 8'h00;
        pix_in.second_byte <= 8'h00;
        cfg_fmt        = FMT_MONO;
        cfg_inv        = 1'b0;
        cfg_tbl        = TBL_ZERO;
        src_idle_pct   = 6;
        snk_idle_pct   = 57;
        mismatch_count = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PATTERN_N; r++) begin
            row = PATTERN_ROWS[r];
            if (row.fmt != cfg_fmt || row.inv != cfg_inv || row.tbl != cfg_tbl) begin
                settle(4);
                load_config(row.fmt, {1'b0, row.inv}, row.tbl);
            end
            send_pixels(row.byte_a, row.byte_b);
            if (row.typed) begin
                n = (row.fmt == FMT_MONO || row.fmt == FMT_THREE) ? 4 : 1;
                for (int k = 0; k < n; k++)
                    pending_bytes.push_back('{row.want, k == n - 1});
            end else begin
                predict_panel_bytes(row.byte_a, row.byte_b);
            end
        end

        for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
            settle(4);
            if (phase == 4) begin
                src_idle_pct = 57;
                snk_idle_pct = 6;
            end else if (phase == 8) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            load_config(t_fmt'(phase[1:0]), 2'($urandom_range(3)), 2'($urandom_range(3)));
            for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
                if (cfg_fmt == FMT_PALETTE) begin
                    a = ($urandom_range(3) != 0) ? PALETTE_KEYS[4'($urandom_range(9))]
                                                 : 8'($urandom_range(255));
                    b = ($urandom_range(3) != 0) ? PALETTE_KEYS[4'($urandom_range(9))]
                                                 : 8'($urandom_range(255));
                end else begin
                    a = 8'($urandom_range(255));
                    b = 8'($urandom_range(255));
                end
                send_pixels(a, b);
                predict_panel_bytes(a, b);
            end
        end

        settle(8);
        if (mismatch_count == 0)
            $display("seven_color_pixel_format_packer_top: match");
        else
            $display("seven_color_pixel_format_packer_top: mismatch");
        $finish;
    end

endmodule
